// ===== rtl/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the RGB box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_ROWS     = 1024;
   localparam int MAX_KERNEL   = 7;
   localparam int CHANNEL_BITS = 8;
   localparam int COL_BITS     = 10;
   localparam int SLOT_BITS    = 3;
   localparam int KSIZE_BITS   = 3;
   localparam int DIM_BITS     = 11;
   localparam int COUNT_BITS   = 21;
   localparam int RAM_DEPTH    = MAX_KERNEL * MAX_WIDTH;
   localparam int ADDR_BITS    = $clog2(RAM_DEPTH);
   localparam int PIXEL_BITS   = 3 * CHANNEL_BITS;
   localparam int SUM_BITS     = 14;
   localparam int DIVISOR_BITS = 6;
   localparam int STEP_BITS    = 4;
   localparam int CSR_ADDR_BITS = 4;

   localparam logic [7:0] ALPHA_VALUE = 8'hff;

   localparam logic [1:0] REG_KERNEL_WIDTH  = 2'd0;
   localparam logic [1:0] REG_KERNEL_HEIGHT = 2'd1;
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd2;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd3;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic       drain;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic [9:0] out_row;
      logic [9:0] out_col;
      logic       frame_end;
      logic       setting_error;
   } rsp_item_type;

   typedef struct packed {
      logic                  store;
      logic                  emit;
      logic                  rd_en;
      logic [KSIZE_BITS-1:0] dr;
      logic [KSIZE_BITS-1:0] dc;
      logic                  acc_en;
      logic                  div_init;
      logic                  div_step;
   } cmd_type;

   typedef struct packed {
      logic                  emit_now;
      logic                  store_now;
      logic [KSIZE_BITS-1:0] cols;
      logic [KSIZE_BITS-1:0] rows;
   } status_type;

endpackage

// ===== rtl/bmf_ram.sv =====
// ----------------------------------------------------------------------------
// bmf_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 7168
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/bmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmf_ctrl
// Sequencer: window read sweep, accumulate, divide, present result.
// ----------------------------------------------------------------------------
module bmf_ctrl import bmf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_INIT = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(SUM_BITS - 1);

   logic [2:0]            state_ff, state_in;
   logic [KSIZE_BITS-1:0] dr_ff, dr_in, dc_ff, dc_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  acc_en_ff, acc_en_in;
   logic                  accept;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in  = state_ff;
      dr_in     = dr_ff;
      dc_in     = dc_ff;
      step_in   = step_ff;
      acc_en_in = 1'b0;
      cmd       = '0;
      cmd.dr    = dr_ff;
      cmd.dc    = dc_ff;
      cmd.acc_en = acc_en_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.store = status.store_now;
               cmd.emit  = status.emit_now;
               dr_in     = '0;
               dc_in     = '0;
               if (status.emit_now) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            acc_en_in = 1'b1;
            if (dc_ff == status.cols - 1'b1) begin
               dc_in = '0;
               if (dr_ff == status.rows - 1'b1) begin
                  state_in = S_WAIT;
               end else begin
                  dr_in = dr_ff + 1'b1;
               end
            end else begin
               dc_in = dc_ff + 1'b1;
            end
         end
         S_WAIT: begin
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         acc_en_ff <= 1'b0;
         dr_ff     <= '0;
         dc_ff     <= '0;
         step_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         acc_en_ff <= acc_en_in;
         dr_ff     <= dr_in;
         dc_ff     <= dc_in;
         step_ff   <= step_in;
      end
   end

   a_read_feeds_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> cmd.acc_en)
      else $error("read data not accumulated");

   a_emit_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && status.emit_now) |=> (state_ff == S_READ))
      else $error("emission did not start window sweep");

   a_div_ends_in_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && step_ff == LAST_STEP) |=> (state_ff == S_OUT))
      else $error("divider did not finish in time");

endmodule

// ===== rtl/bmf_datapath.sv =====
// ----------------------------------------------------------------------------
// bmf_datapath
// Registers, frame counters, row store, window sums and dividers.
// ----------------------------------------------------------------------------
module bmf_datapath import bmf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata,
   output logic [31:0]              csr_rdata,
   input  req_item_type             req_data,
   output rsp_item_type             rsp_data,
   input  cmd_type                  cmd,
   output status_type               status
);

   logic [KSIZE_BITS-1:0] kw_ff, kh_ff;
   logic [DIM_BITS-1:0]   iw_ff, ih_ff;

   logic                  kerr;
   logic [KSIZE_BITS-1:0] kw_e, kh_e;
   logic [1:0]            hw, hh;
   logic [DIM_BITS-1:0]   w_e, h_e;
   logic [2*DIM_BITS-1:0] total_full;
   logic [COUNT_BITS-1:0] total, lag, emit_next;

   logic [COL_BITS-1:0]   in_col_ff, em_col_ff, em_row_ff;
   logic [DIM_BITS-1:0]   in_row_ff;
   logic [SLOT_BITS-1:0]  in_slot_ff, em_slot_ff;
   logic [COUNT_BITS-1:0] rx_ff, emit_ff;

   logic                  interior, fend;
   logic [1:0]            hwi, hhi;
   logic [SLOT_BITS-1:0]  base_slot;

   logic [SLOT_BITS-1:0]    b_slot_ff;
   logic [COL_BITS-1:0]     b_col_ff, o_row_ff, o_col_ff;
   logic [KSIZE_BITS-1:0]   cols_ff, rows_ff;
   logic [DIVISOR_BITS-1:0] div_ff;
   logic                    o_fend_ff, o_err_ff;

   logic [SLOT_BITS:0]      rd_slot_sum;
   logic [SLOT_BITS-1:0]    rd_slot;
   logic [COL_BITS-1:0]     rd_col;
   logic [ADDR_BITS-1:0]    rd_addr, wr_addr;
   logic [PIXEL_BITS-1:0]   rd_data;

   logic [SUM_BITS-1:0]     acc_ff [3];
   logic [SUM_BITS-1:0]     quo_ff [3];
   logic [DIVISOR_BITS-1:0] rem_ff [3];

   // Effective settings: an even kernel falls back to a 1x1 window.
   assign kerr = ~kw_ff[0] | ~kh_ff[0];
   assign kw_e = kerr ? KSIZE_BITS'(1) : kw_ff;
   assign kh_e = kerr ? KSIZE_BITS'(1) : kh_ff;
   assign hw   = kw_e[2:1];
   assign hh   = kh_e[2:1];
   assign w_e  = (iw_ff < DIM_BITS'(3)) ? DIM_BITS'(3) :
                 (iw_ff > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : iw_ff;
   assign h_e  = (ih_ff < DIM_BITS'(3)) ? DIM_BITS'(3) :
                 (ih_ff > DIM_BITS'(MAX_ROWS)) ? DIM_BITS'(MAX_ROWS) : ih_ff;
   assign total_full = w_e * h_e;
   assign total      = total_full[COUNT_BITS-1:0];
   assign lag        = COUNT_BITS'(hh) * COUNT_BITS'(w_e) + COUNT_BITS'(hw);
   assign emit_next  = emit_ff + 1'b1;
   assign fend       = (emit_next >= total);

   assign interior = ({1'b0, em_row_ff} >= DIM_BITS'(hh))
                   && (({1'b0, em_row_ff} + DIM_BITS'(hh)) < h_e)
                   && ({1'b0, em_col_ff} >= DIM_BITS'(hw))
                   && (({1'b0, em_col_ff} + DIM_BITS'(hw)) < w_e);
   assign hwi = interior ? hw : 2'd0;
   assign hhi = interior ? hh : 2'd0;
   assign base_slot = (em_slot_ff >= SLOT_BITS'(hhi)) ? (em_slot_ff - SLOT_BITS'(hhi))
                    : SLOT_BITS'(em_slot_ff + SLOT_BITS'(MAX_KERNEL) - SLOT_BITS'(hhi));

   assign status.store_now = (in_row_ff < h_e) && !req_data.drain;
   assign status.emit_now  = (emit_ff < total)
                          && ((in_row_ff >= h_e) || (!req_data.drain && rx_ff >= lag));
   assign status.cols      = cols_ff;
   assign status.rows      = rows_ff;

   // CSR file; any write restarts the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ff <= KSIZE_BITS'(3);
         kh_ff <= KSIZE_BITS'(3);
         iw_ff <= DIM_BITS'(640);
         ih_ff <= DIM_BITS'(480);
      end else if (csr_wr) begin
         case (csr_index)
            REG_KERNEL_WIDTH:  kw_ff <= csr_wdata[KSIZE_BITS-1:0];
            REG_KERNEL_HEIGHT: kh_ff <= csr_wdata[KSIZE_BITS-1:0];
            REG_IMAGE_WIDTH:   iw_ff <= csr_wdata[DIM_BITS-1:0];
            REG_IMAGE_HEIGHT:  ih_ff <= csr_wdata[DIM_BITS-1:0];
            default:           kw_ff <= kw_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_KERNEL_WIDTH:  csr_rdata = 32'(kw_ff);
         REG_KERNEL_HEIGHT: csr_rdata = 32'(kh_ff);
         REG_IMAGE_WIDTH:   csr_rdata = 32'(iw_ff);
         REG_IMAGE_HEIGHT:  csr_rdata = 32'(ih_ff);
         default:           csr_rdata = '0;
      endcase
   end

   // Frame position counters.
   always_ff @(posedge clock) begin
      if (reset || csr_wr || (cmd.emit && fend)) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_slot_ff <= '0;
         rx_ff      <= '0;
         em_col_ff  <= '0;
         em_row_ff  <= '0;
         em_slot_ff <= '0;
         emit_ff    <= '0;
      end else begin
         if (cmd.store) begin
            rx_ff <= rx_ff + 1'b1;
            if ({1'b0, in_col_ff} + 1'b1 >= w_e) begin
               in_col_ff  <= '0;
               in_row_ff  <= in_row_ff + 1'b1;
               in_slot_ff <= (in_slot_ff == SLOT_BITS'(MAX_KERNEL - 1)) ? '0
                           : in_slot_ff + 1'b1;
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end
         if (cmd.emit) begin
            emit_ff <= emit_next;
            if ({1'b0, em_col_ff} + 1'b1 >= w_e) begin
               em_col_ff  <= '0;
               em_row_ff  <= em_row_ff + 1'b1;
               em_slot_ff <= (em_slot_ff == SLOT_BITS'(MAX_KERNEL - 1)) ? '0
                           : em_slot_ff + 1'b1;
            end else begin
               em_col_ff <= em_col_ff + 1'b1;
            end
         end
      end
   end

   // Latch the window of the pixel being emitted.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         b_slot_ff <= base_slot;
         b_col_ff  <= em_col_ff - COL_BITS'(hwi);
         cols_ff   <= interior ? kw_e : KSIZE_BITS'(1);
         rows_ff   <= interior ? kh_e : KSIZE_BITS'(1);
         div_ff    <= interior ? DIVISOR_BITS'(kw_e) * DIVISOR_BITS'(kh_e)
                               : DIVISOR_BITS'(1);
         o_row_ff  <= em_row_ff;
         o_col_ff  <= em_col_ff;
         o_fend_ff <= fend;
         o_err_ff  <= kerr;
      end
   end

   assign rd_slot_sum = {1'b0, b_slot_ff} + (SLOT_BITS+1)'(cmd.dr);
   assign rd_slot     = (rd_slot_sum >= (SLOT_BITS+1)'(MAX_KERNEL))
                      ? SLOT_BITS'(rd_slot_sum - (SLOT_BITS+1)'(MAX_KERNEL))
                      : rd_slot_sum[SLOT_BITS-1:0];
   assign rd_col      = b_col_ff + COL_BITS'(cmd.dc);
   assign rd_addr     = ADDR_BITS'(rd_slot) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(rd_col);
   assign wr_addr     = ADDR_BITS'(in_slot_ff) * ADDR_BITS'(MAX_WIDTH)
                      + ADDR_BITS'(in_col_ff);

   bmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(RAM_DEPTH)) u_row_store (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (wr_addr),
      .wr_data ({req_data.in_red, req_data.in_green, req_data.in_blue}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Window sums and restoring dividers, one quotient bit a cycle.
   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic [CHANNEL_BITS-1:0] pix;
      logic [DIVISOR_BITS:0]   trial;
      assign pix   = rd_data[(2-ch)*CHANNEL_BITS +: CHANNEL_BITS];
      assign trial = {rem_ff[ch], quo_ff[ch][SUM_BITS-1]};

      always_ff @(posedge clock) begin
         if (cmd.emit) begin
            acc_ff[ch] <= '0;
         end else if (cmd.acc_en) begin
            acc_ff[ch] <= acc_ff[ch] + SUM_BITS'(pix);
         end
         if (cmd.div_init) begin
            rem_ff[ch] <= '0;
            quo_ff[ch] <= acc_ff[ch];
         end else if (cmd.div_step) begin
            if (trial >= {1'b0, div_ff}) begin
               rem_ff[ch] <= DIVISOR_BITS'(trial - {1'b0, div_ff});
               quo_ff[ch] <= {quo_ff[ch][SUM_BITS-2:0], 1'b1};
            end else begin
               rem_ff[ch] <= trial[DIVISOR_BITS-1:0];
               quo_ff[ch] <= {quo_ff[ch][SUM_BITS-2:0], 1'b0};
            end
         end
      end
   end

   assign rsp_data.out_red       = quo_ff[0][CHANNEL_BITS-1:0];
   assign rsp_data.out_green     = quo_ff[1][CHANNEL_BITS-1:0];
   assign rsp_data.out_blue      = quo_ff[2][CHANNEL_BITS-1:0];
   assign rsp_data.out_alpha     = ALPHA_VALUE;
   assign rsp_data.out_row       = o_row_ff;
   assign rsp_data.out_col       = o_col_ff;
   assign rsp_data.frame_end     = o_fend_ff;
   assign rsp_data.setting_error = o_err_ff;

endmodule

// ===== rtl/box_mean_filter_rgb.sv =====
// ----------------------------------------------------------------------------
// box_mean_filter_rgb
// Streaming RGB box mean filter with line storage and CSR setup.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   req_item_type (RGB + drain)
//   rsp_      out        rsp_valid/rsp_ready   rsp_item_type (RGB, alpha, pos)
//   csr_      in         APB psel/penable      32-bit registers at 4*index
//
// One item is taken at a time. An item that emits a pixel goes through
// the accept, one row store read per window position (a single read for a
// border pixel), a wait for the read data, a divider load, 14 divider
// steps and the output state, plus the wait on rsp_ready.
// Items with no result do not leave the idle state.
// Reset is synchronous; the row store has no reset and needs none, since
// only written pixels are ever read. req_ready drops while an item is in
// work; a stalled result holds until taken.
// ----------------------------------------------------------------------------
module box_mean_filter_rgb import bmf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_item_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_item_type             rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   cmd_type    cmd;
   status_type status;
   logic       csr_wr;

   // Always ready; write on the access phase.
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   bmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bmf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_wr),
      .csr_index (paddr[3:2]),
      .csr_wdata (pwdata),
      .csr_rdata (prdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
